// ----- rtl/core/cbcr_pkg.sv -----
// ----------------------------------------------------------------------------
// cbcr_pkg
// Shared types and constants for the chunk bounds / centroid reducer.
// ----------------------------------------------------------------------------
package cbcr_pkg;

   localparam int CHUNK_LEN_DEF = 256;

   localparam int POS_W   = 32;
   localparam int SCALE_W = 31;
   localparam int BOX_W   = 34;
   localparam int SIZE_W  = 33;
   localparam int CNT_OUT_W = 9;
   localparam int START_W = 32;
   localparam int AXES    = 3;

   // divide stage sequencing
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   // controller -> datapath
   typedef struct packed {
      logic acc_en;     // splat accepted, fold it in
      logic close;      // splat closes the chunk, snapshot and start divide
      logic div_step;   // advance the dividers one bit
      logic out_load;   // move finished summary to the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic close_hit;  // the splat at the input would close the chunk
   } status_type;

endpackage

// ----- rtl/core/cbcr_div.sv -----
// ----------------------------------------------------------------------------
// cbcr_div
// Restoring signed divider, one quotient bit per step, truncating toward zero.
// ----------------------------------------------------------------------------
module cbcr_div import cbcr_pkg::*; #(
   parameter int SUM_W = 40,
   parameter int CNT_W = 9
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic                    step,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [CNT_W-1:0] divisor,
   output logic        [POS_W-1:0] quotient
);

   logic             neg_ff;
   logic [SUM_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] d_ff;
   logic [CNT_W:0]   rem_sh;
   logic [CNT_W:0]   diff;
   logic [POS_W-1:0] q_low;

   always_comb begin
      rem_sh = {rem_ff, q_ff[SUM_W-1]};
      diff   = rem_sh - {1'b0, d_ff};
      if (load) begin
         q_in   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in = '0;
      end else if (step) begin
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            q_in   = {q_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            q_in   = {q_ff[SUM_W-2:0], 1'b0};
         end
      end else begin
         rem_in = rem_ff;
         q_in   = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (load) begin
         neg_ff <= dividend[SUM_W-1];
         d_ff   <= divisor;
      end
   end

   assign q_low    = q_ff[POS_W-1:0];
   assign quotient = neg_ff ? (~q_low + POS_W'(1)) : q_low;

endmodule

// ----- rtl/core/cbcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbcr_ctrl
// Handshake and divide-stage sequencer.
// ----------------------------------------------------------------------------
module cbcr_ctrl import cbcr_pkg::*; #(
   parameter int SUM_W = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int STEP_W = $clog2(SUM_W);

   div_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic              step_last;
   logic              out_free;

   assign step_last = (step_ff == STEP_W'(SUM_W - 1));
   assign out_free  = !out_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (cmd.close) state_in = DIV_RUN;
         DIV_RUN:  if (step_last) state_in = DIV_HOLD;
         DIV_HOLD: if (out_free)  state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = (state_ff == DIV_IDLE) || !status.close_hit;
      cmd.acc_en   = req_tvalid && req_tready;
      cmd.close    = cmd.acc_en && status.close_hit;
      cmd.div_step = (state_ff == DIV_RUN);
      cmd.out_load = (state_ff == DIV_HOLD) && out_free;
      step_in      = cmd.div_step ? step_ff + STEP_W'(1) : '0;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_close_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.close |-> state_ff == DIV_IDLE)
      else $error("chunk closed while divide stage busy");

   a_close_starts_run : assert property (@(posedge clock) disable iff (reset)
      cmd.close |=> state_ff == DIV_RUN && step_ff == '0)
      else $error("divide did not start after chunk close");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_valid_ff || rsp_tready)
      else $error("output register overwritten before taken");

   a_run_ends_hold : assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_RUN && step_last |=> state_ff == DIV_HOLD)
      else $error("divide ran past its last step");

endmodule

// ----- rtl/core/cbcr_datapath.sv -----
// ----------------------------------------------------------------------------
// cbcr_datapath
// Chunk accumulators, close snapshot, centroid dividers and output register.
// ----------------------------------------------------------------------------
module cbcr_datapath import cbcr_pkg::*; #(
   parameter int CHUNK_LEN = CHUNK_LEN_DEF,
   parameter int SUM_W     = 40,
   parameter int CNT_W     = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic signed [POS_W-1:0]    pos_x,
   input  logic signed [POS_W-1:0]    pos_y,
   input  logic signed [POS_W-1:0]    pos_z,
   input  logic        [SCALE_W-1:0]  scale_x,
   input  logic        [SCALE_W-1:0]  scale_y,
   input  logic        [SCALE_W-1:0]  scale_z,
   input  logic                       final_splat,
   output logic        [START_W-1:0]  chunk_start,
   output logic        [CNT_OUT_W-1:0] chunk_count,
   output logic signed [POS_W-1:0]    center_x,
   output logic signed [POS_W-1:0]    center_y,
   output logic signed [POS_W-1:0]    center_z,
   output logic        [SCALE_W-1:0]  largest_radius,
   output logic signed [BOX_W-1:0]    box_min_x,
   output logic signed [BOX_W-1:0]    box_min_y,
   output logic signed [BOX_W-1:0]    box_min_z,
   output logic        [SIZE_W-1:0]   box_size_x,
   output logic        [SIZE_W-1:0]   box_size_y,
   output logic        [SIZE_W-1:0]   box_size_z
);

   logic signed [POS_W-1:0]   pos [AXES];
   logic        [SCALE_W-1:0] radius;
   logic        [CNT_W-1:0]   count_new;

   // accumulators
   logic signed [SUM_W-1:0]   sum_ff [AXES];
   logic signed [SUM_W-1:0]   sum_in [AXES];
   logic signed [BOX_W-1:0]   lo_ff  [AXES];
   logic signed [BOX_W-1:0]   lo_in  [AXES];
   logic signed [BOX_W-1:0]   hi_ff  [AXES];
   logic signed [BOX_W-1:0]   hi_in  [AXES];
   logic        [SCALE_W-1:0] peak_ff, peak_in;
   logic        [CNT_W-1:0]   fill_ff;
   logic        [START_W-1:0] start_ff;

   // snapshot of a closed chunk while its centroid divides
   logic        [START_W-1:0] snap_start_ff;
   logic        [CNT_W-1:0]   snap_count_ff;
   logic        [SCALE_W-1:0] snap_peak_ff;
   logic signed [BOX_W-1:0]   snap_lo_ff [AXES];
   logic signed [BOX_W-1:0]   snap_hi_ff [AXES];
   logic        [POS_W-1:0]   quot [AXES];

   // output register
   logic        [START_W-1:0]   o_start_ff;
   logic        [CNT_OUT_W-1:0] o_count_ff;
   logic signed [POS_W-1:0]     o_center_ff [AXES];
   logic        [SCALE_W-1:0]   o_peak_ff;
   logic signed [BOX_W-1:0]     o_min_ff    [AXES];
   logic        [SIZE_W-1:0]    o_size_ff   [AXES];
   logic signed [BOX_W-1:0]     extent      [AXES];

   assign pos[0] = pos_x;
   assign pos[1] = pos_y;
   assign pos[2] = pos_z;

   always_comb begin
      radius = scale_x;
      if (scale_y > radius) radius = scale_y;
      if (scale_z > radius) radius = scale_z;
      count_new = fill_ff + CNT_W'(1);
      status.close_hit = (fill_ff == CNT_W'(CHUNK_LEN - 1)) || final_splat;
      peak_in = (radius > peak_ff) ? radius : peak_ff;
      for (int k = 0; k < AXES; k++) begin
         sum_in[k] = sum_ff[k] + SUM_W'(pos[k]);
         lo_in[k]  = BOX_W'(pos[k]) - $signed({3'b000, radius});
         hi_in[k]  = BOX_W'(pos[k]) + $signed({3'b000, radius});
         if (fill_ff != '0) begin
            if (lo_ff[k] < lo_in[k]) lo_in[k] = lo_ff[k];
            if (hi_ff[k] > hi_in[k]) hi_in[k] = hi_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         start_ff <= '0;
         peak_ff  <= '0;
         for (int k = 0; k < AXES; k++) sum_ff[k] <= '0;
      end else if (cmd.close) begin
         fill_ff  <= '0;
         start_ff <= start_ff + START_W'(count_new);
         peak_ff  <= '0;
         for (int k = 0; k < AXES; k++) sum_ff[k] <= '0;
      end else if (cmd.acc_en) begin
         fill_ff  <= count_new;
         peak_ff  <= peak_in;
         for (int k = 0; k < AXES; k++) sum_ff[k] <= sum_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         for (int k = 0; k < AXES; k++) begin
            lo_ff[k] <= lo_in[k];
            hi_ff[k] <= hi_in[k];
         end
      end
      if (cmd.close) begin
         snap_start_ff <= start_ff;
         snap_count_ff <= count_new;
         snap_peak_ff  <= peak_in;
         for (int k = 0; k < AXES; k++) begin
            snap_lo_ff[k] <= lo_in[k];
            snap_hi_ff[k] <= hi_in[k];
         end
      end
   end

   for (genvar g = 0; g < AXES; g++) begin : g_div
      cbcr_div #(
         .SUM_W (SUM_W),
         .CNT_W (CNT_W)
      ) u_div (
         .clock    (clock),
         .load     (cmd.close),
         .step     (cmd.div_step),
         .dividend (sum_in[g]),
         .divisor  (count_new),
         .quotient (quot[g])
      );
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) extent[k] = snap_hi_ff[k] - snap_lo_ff[k];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_start_ff <= snap_start_ff;
         o_count_ff <= CNT_OUT_W'(snap_count_ff);
         o_peak_ff  <= snap_peak_ff;
         for (int k = 0; k < AXES; k++) begin
            o_center_ff[k] <= $signed(quot[k]);
            o_min_ff[k]    <= snap_lo_ff[k];
            o_size_ff[k]   <= extent[k][SIZE_W-1:0];
         end
      end
   end

   assign chunk_start    = o_start_ff;
   assign chunk_count    = o_count_ff;
   assign largest_radius = o_peak_ff;
   assign center_x       = o_center_ff[0];
   assign center_y       = o_center_ff[1];
   assign center_z       = o_center_ff[2];
   assign box_min_x      = o_min_ff[0];
   assign box_min_y      = o_min_ff[1];
   assign box_min_z      = o_min_ff[2];
   assign box_size_x     = o_size_ff[0];
   assign box_size_y     = o_size_ff[1];
   assign box_size_z     = o_size_ff[2];

endmodule

// ----- rtl/core/chunk_bounds_centroid_reduce.sv -----
// ----------------------------------------------------------------------------
// chunk_bounds_centroid_reduce
// Per-chunk centroid, peak radius and bounding box of a splat stream.
// ----------------------------------------------------------------------------
// The block folds one splat per cycle, while req_tready is high, into running
// chunk accumulators (position sums, peak radius, box corners). A splat that
// fills the chunk, or carries the final flag, closes it: the totals are
// snapshotted and three restoring dividers form the centroids in the
// background, one quotient bit per cycle over the SUM_W-bit sums (40 bits at
// the default chunk size of 256); the summary then moves into the output
// register once that register is free. Splats of the next chunk keep flowing
// at one per cycle meanwhile; only the next closing splat waits until the
// divide stage is free. The output register holds a summary until the downstream side takes it.
// ----------------------------------------------------------------------------
module chunk_bounds_centroid_reduce import cbcr_pkg::*; #(
   parameter int CHUNK_LEN = CHUNK_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], scale_x[126:96],
   //            scale_y[157:127], scale_z[188:158], zero pad [191:189]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,
   // req_tlast: final_splat, closes a partial chunk
   input  logic         req_tlast,
   // rsp_tdata: chunk_start[31:0], chunk_count[40:32], center_x[72:41],
   //            center_y[104:73], center_z[136:105], largest_radius[167:137],
   //            box_min_x[201:168], box_min_y[235:202], box_min_z[269:236],
   //            box_size_x[302:270], box_size_y[335:303], box_size_z[368:336],
   //            zero pad [375:369]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [375:0] rsp_tdata
);

   // sums grow by log2 of the chunk size; the count must hold the chunk size
   localparam int SUM_W = POS_W + $clog2(CHUNK_LEN);
   localparam int CNT_W = $clog2(CHUNK_LEN + 1);

   cmd_type    cmd;
   status_type status;

   logic        [START_W-1:0]   chunk_start;
   logic        [CNT_OUT_W-1:0] chunk_count;
   logic signed [POS_W-1:0]     center_x, center_y, center_z;
   logic        [SCALE_W-1:0]   largest_radius;
   logic signed [BOX_W-1:0]     box_min_x, box_min_y, box_min_z;
   logic        [SIZE_W-1:0]    box_size_x, box_size_y, box_size_z;

   cbcr_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // unpack the request transaction straight into the datapath
   cbcr_datapath #(
      .CHUNK_LEN  (CHUNK_LEN),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pos_x          (req_tdata[31:0]),
      .pos_y          (req_tdata[63:32]),
      .pos_z          (req_tdata[95:64]),
      .scale_x        (req_tdata[126:96]),
      .scale_y        (req_tdata[157:127]),
      .scale_z        (req_tdata[188:158]),
      .final_splat    (req_tlast),
      .chunk_start    (chunk_start),
      .chunk_count    (chunk_count),
      .center_x       (center_x),
      .center_y       (center_y),
      .center_z       (center_z),
      .largest_radius (largest_radius),
      .box_min_x      (box_min_x),
      .box_min_y      (box_min_y),
      .box_min_z      (box_min_z),
      .box_size_x     (box_size_x),
      .box_size_y     (box_size_y),
      .box_size_z     (box_size_z)
   );

   // pack the summary, first field lowest
   assign rsp_tdata = {7'b0000000,
                       box_size_z, box_size_y, box_size_x,
                       box_min_z, box_min_y, box_min_x,
                       largest_radius,
                       center_z, center_y, center_x,
                       chunk_count, chunk_start};

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunk bounds / centroid reducer.
// ----------------------------------------------------------------------------
// Splats go in on the req_ stream. Each accepted transaction is folded into a
// chunk tracker kept in the bench (position sums, peak radius, box corners).
// When a splat closes a chunk, the tracker queues the summary that the block
// should produce. A sink process takes rsp_ transactions and compares them,
// field by field, with the oldest queued summary. The test tasks cover field
// extremes, centroid truncation, chunks closed by size and by the final flag,
// random streams, a long output stall and bursts without any idling.
// ----------------------------------------------------------------------------
module tb_top import cbcr_pkg::*; ();

   localparam int CHUNK        = CHUNK_LEN_DEF;
   localparam int REQ_W        = 192;
   localparam int RSP_W        = 376;
   // Idle time allowed past the last summary before the final report.
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 600;

   localparam logic [POS_W-1:0]   POS_MIN   = 32'h8000_0000;
   localparam logic [POS_W-1:0]   POS_MAX   = 32'h7FFF_FFFF;
   localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

   typedef struct packed {
      logic [AXES-1:0][POS_W-1:0]   pos;
      logic [AXES-1:0][SCALE_W-1:0] scale;
      logic                         last_flag;
   } splat_type;

   typedef struct packed {
      logic [START_W-1:0]           start;
      logic [CNT_OUT_W-1:0]         count;
      logic [AXES-1:0][POS_W-1:0]   center;
      logic [SCALE_W-1:0]           radius;
      logic [AXES-1:0][BOX_W-1:0]   box_min;
      logic [AXES-1:0][SIZE_W-1:0]  box_size;
   } chunk_summary_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, zero pad
   logic [REQ_W-1:0] req_tdata;
   // final_splat
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // chunk_start, chunk_count, center_x/y/z, largest_radius,
   // box_min_x/y/z, box_size_x/y/z, zero pad
   logic [RSP_W-1:0] rsp_tdata;

   // Chunk tracker state, mirrors what the block accumulates.
   longint             pos_sum [AXES];
   longint             box_lo  [AXES];
   longint             box_hi  [AXES];
   logic [SCALE_W-1:0] peak_radius;
   int unsigned        open_count;
   logic [START_W-1:0] open_start;

   chunk_summary_type pending_summaries[$];

   // Shared knobs: burst_mode removes idling on both sides, hold_request asks
   // the sink for one long stall.
   bit  burst_mode;
   int  hold_request;

   int  splats_sent;
   int  summaries_seen;
   int  size_closes;
   int  flag_closes;
   int  mismatches;

   string axis_names[AXES] = '{"x", "y", "z"};

   chunk_bounds_centroid_reduce #(
      .CHUNK_LEN(CHUNK)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("chunk_bounds_centroid_reduce verification failed");
      $finish;
   end

   // Mostly back-to-back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [REQ_W-1:0] pack_splat(input splat_type s);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int k = 0; k < AXES; k++) begin
         d[POS_W*k +: POS_W]                 = s.pos[k];
         d[POS_W*AXES + SCALE_W*k +: SCALE_W] = s.scale[k];
      end
      return d;
   endfunction

   function automatic chunk_summary_type unpack_summary(input logic [RSP_W-1:0] d);
      chunk_summary_type c;
      c.start  = d[START_W-1:0];
      c.count  = d[START_W +: CNT_OUT_W];
      c.radius = d[137 +: SCALE_W];
      for (int k = 0; k < AXES; k++) begin
         c.center[k]   = d[41 + POS_W*k +: POS_W];
         c.box_min[k]  = d[168 + BOX_W*k +: BOX_W];
         c.box_size[k] = d[270 + SIZE_W*k +: SIZE_W];
      end
      return c;
   endfunction

   // Fold one accepted splat into the open chunk; queue a summary on close.
   function automatic void fold_splat(input splat_type s);
      longint             p;
      longint             lo;
      longint             hi;
      longint             q;
      logic [SCALE_W-1:0] r;
      chunk_summary_type  c;
      r = s.scale[0];
      if (s.scale[1] > r) r = s.scale[1];
      if (s.scale[2] > r) r = s.scale[2];
      if (r > peak_radius) peak_radius = r;
      for (int k = 0; k < AXES; k++) begin
         p  = longint'($signed(s.pos[k]));
         lo = p - longint'(r);
         hi = p + longint'(r);
         pos_sum[k] += p;
         // the first splat of a chunk loads the corners outright
         if (open_count == 0) begin
            box_lo[k] = lo;
            box_hi[k] = hi;
         end else begin
            if (lo < box_lo[k]) box_lo[k] = lo;
            if (hi > box_hi[k]) box_hi[k] = hi;
         end
      end
      open_count++;
      if (open_count < CHUNK && !s.last_flag) return;

      // A full chunk that also carries the flag still closes only once.
      if (open_count >= CHUNK) size_closes++;
      else flag_closes++;
      c.start  = open_start;
      c.count  = open_count[CNT_OUT_W-1:0];
      c.radius = peak_radius;
      for (int k = 0; k < AXES; k++) begin
         q              = pos_sum[k] / longint'(open_count);  // truncates toward zero
         c.center[k]    = q[POS_W-1:0];
         c.box_min[k]   = box_lo[k][BOX_W-1:0];
         q              = box_hi[k] - box_lo[k];
         c.box_size[k]  = q[SIZE_W-1:0];
         pos_sum[k]     = 0;
         box_lo[k]      = 0;
         box_hi[k]      = 0;
      end
      pending_summaries.push_back(c);
      open_start  = open_start + open_count[START_W-1:0];
      peak_radius = '0;
      open_count  = 0;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_summary(input chunk_summary_type got);
      chunk_summary_type want;
      summaries_seen++;
      if (pending_summaries.size() == 0) begin
         $error("chunk summary arrived with none pending (chunk_start 0x%0h)",
                got.start);
         mismatches++;
         return;
      end
      want = pending_summaries.pop_front();
      compare_field("chunk_start", want.start, got.start);
      compare_field("chunk_count", want.count, got.count);
      compare_field("largest_radius", want.radius, got.radius);
      for (int k = 0; k < AXES; k++) begin
         compare_field({"center_", axis_names[k]}, want.center[k], got.center[k]);
         compare_field({"box_min_", axis_names[k]}, want.box_min[k], got.box_min[k]);
         compare_field({"box_size_", axis_names[k]}, want.box_size[k], got.box_size[k]);
      end
   endfunction

   // Result sink: check each transaction, then choose rsp_tready for the next
   // edge. A pending hold request turns into a long stall counted here.
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_summary(unpack_summary(rsp_tdata));
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (burst_mode || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   // Offer one splat and hold it until the block takes it. tvalid stays high
   // on return so that a following splat with no gap goes out back to back.
   task automatic send_splat(input splat_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_splat(s);
      req_tlast  <= s.last_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fold_splat(s);
      splats_sent++;
   endtask

   function automatic splat_type make_splat(input logic [POS_W-1:0] px,
                                            input logic [POS_W-1:0] py,
                                            input logic [POS_W-1:0] pz,
                                            input logic [SCALE_W-1:0] sx,
                                            input logic [SCALE_W-1:0] sy,
                                            input logic [SCALE_W-1:0] sz, input logic fin);
      splat_type s;
      s.pos       = {pz, py, px};
      s.scale     = {sz, sy, sx};
      s.last_flag = fin;
      return s;
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return POS_MIN;
               1: return POS_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         1: return POS_W'($urandom_range(0, 2000)) - POS_W'(1000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] rand_scale();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 7))
         0, 1: return '0;
         2: return SCALE_W'($urandom_range(0, 32'h0010_0000));
         3: return SCALE_MAX;
         default: return raw[SCALE_W-1:0];
      endcase
   endfunction

   function automatic splat_type rand_splat(input logic fin);
      return make_splat(rand_pos(), rand_pos(), rand_pos(),
                        rand_scale(), rand_scale(), rand_scale(), fin);
   endfunction

   // Field extremes, truncating centroids and each scale axis as the radius.
   task automatic test_extremes();
      send_splat(make_splat(0, 0, 0, 31'd0, 31'd0, 31'd0, 1'b1));
      send_splat(make_splat(POS_MIN, POS_MIN, POS_MIN, SCALE_MAX, SCALE_MAX, SCALE_MAX, 1'b1));
      send_splat(make_splat(POS_MAX, POS_MAX, POS_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX, 1'b1));
      // sums of -1 over two splats: centroid 0, not -1
      send_splat(make_splat(POS_MAX, POS_MIN, 0, 31'd0, 31'd0, 31'd0, 1'b0));
      send_splat(make_splat(POS_MIN, POS_MAX, -1, 31'd0, 31'd0, 31'd0, 1'b1));
      // -2/3, 16/3 and -16/3; radius taken from x, then y, then z
      send_splat(make_splat(-1, 5, -5, 31'd3, 31'd0, 31'd0, 1'b0));
      send_splat(make_splat(-1, 5, -5, 31'd0, 31'd7, 31'd0, 1'b0));
      send_splat(make_splat(0, 6, -6, 31'd0, 31'd0, 31'd9, 1'b1));
      // alternating bit patterns on every field
      send_splat(make_splat(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0));
      send_splat(make_splat(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 1'b1));
      // box corners set by later splats, not the first one
      send_splat(make_splat(100, 100, 100, 31'd10, 31'd10, 31'd10, 1'b0));
      send_splat(make_splat(50, 200, -300, 31'd0, 31'd0, 31'd0, 1'b0));
      send_splat(make_splat(150, -20, 400, 31'd5, 31'd5, 31'd5, 1'b1));
      send_splat(make_splat(65536, -65536, 1, 31'd1, 31'd2, 31'd3, 1'b1));
   endtask

   // One chunk closed by size alone, one where the last splat also has the flag.
   task automatic test_full_chunks();
      for (int i = 0; i < CHUNK; i++) send_splat(rand_splat(1'b0));
      for (int i = 0; i < CHUNK; i++) send_splat(rand_splat(i == CHUNK - 1));
   endtask

   task automatic test_random_stream(input int n);
      for (int i = 0; i < n; i++) send_splat(rand_splat($urandom_range(0, 15) == 0));
   endtask

   // Stall the sink for a long stretch while short chunks keep arriving:
   // output register and divide stage fill, then req_tready must drop.
   task automatic test_output_stall();
      burst_mode   = 1'b1;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 80; i++) send_splat(rand_splat(i % 2 == 1));
      burst_mode   = 1'b0;
   endtask

   task automatic test_bursts(input int n);
      burst_mode = 1'b1;
      for (int i = 0; i < n; i++) send_splat(rand_splat($urandom_range(0, 7) == 0));
      burst_mode = 1'b0;
   endtask

   initial begin : stimulus
      for (int k = 0; k < AXES; k++) begin
         pos_sum[k] = 0;
         box_lo[k]  = 0;
         box_hi[k]  = 0;
      end
      peak_radius    = '0;
      open_count     = 0;
      open_start     = '0;
      burst_mode     = 1'b0;
      hold_request   = 0;
      splats_sent    = 0;
      summaries_seen = 0;
      size_closes    = 0;
      flag_closes    = 0;
      mismatches     = 0;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_full_chunks();
      test_random_stream(760);
      test_output_stall();
      test_bursts(300);

      // Drop tvalid, let every queued summary come back, then watch for strays.
      req_tvalid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d splats, checked %0d chunk summaries (%0d closed full, %0d by flag).",
               splats_sent, summaries_seen, size_closes, flag_closes);
      $display("Covered field extremes, truncating centroids, long output stall, bursts.");
      if (mismatches == 0) begin
         $display("chunk_bounds_centroid_reduce verification clean");
      end else begin
         $display("chunk_bounds_centroid_reduce verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/cbcr_pkg.sv
rtl/core/cbcr_div.sv
rtl/core/cbcr_ctrl.sv
rtl/core/cbcr_datapath.sv
rtl/core/chunk_bounds_centroid_reduce.sv
tb/sv/tb_top.sv
